// ===== rtl/sdt_pkg.sv =====
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types, character codes and the BCD shift step for the
// identifier-to-text formatter.
// ----------------------------------------------------------------------------
package sdt_pkg;

	localparam int MAX_SUBS_DEF = 16;

	localparam int BIN_W      = 48;
	localparam int BCD_DIGITS = 15;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int IDX_W      = 4;
	localparam int STEP_W     = 5;

	localparam logic [STEP_W-1:0] REV_STEPS  = 5'd4;
	localparam logic [STEP_W-1:0] AUTH_STEPS = 5'd24;
	localparam logic [STEP_W-1:0] SUB_STEPS  = 5'd16;

	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_NONE = 8'h00;

	typedef enum logic {
		ITEM_HDR = 1'b0,
		ITEM_SUB = 1'b1
	} item_cmd_t;

	typedef enum logic [1:0] {
		PH_REV,
		PH_AUTH,
		PH_SUB
	} phase_t;

	typedef enum logic [1:0] {
		SEL_S,
		SEL_DASH,
		SEL_DIGIT,
		SEL_ERR
	} char_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_LEAD_S,
		ST_DASH,
		ST_LOAD,
		ST_CONV,
		ST_COUNT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic      capture;
		logic      load;
		logic      step;
		logic      count;
		logic      put;
		char_sel_t sel;
		logic      last;
		logic      advance;
		phase_t    phase;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic conv_done;
		logic idx_zero;
	} dp_status_t;

	function automatic logic [BCD_W-1:0] bcd_shift(input logic [BCD_W-1:0] bcd,
			input logic bit_in);
		logic [BCD_W-1:0] adj;
		adj = bcd;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (adj[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
			end
		end
		return {adj[BCD_W-2:0], bit_in};
	endfunction

endpackage

// ===== rtl/sdt_datapath.sv =====
// ----------------------------------------------------------------------------
// sdt_datapath
// Operand capture, two-bit-per-cycle binary to BCD conversion, top digit
// search and the output character register.
// ----------------------------------------------------------------------------
module sdt_datapath
	import sdt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           dp_cmd,
	output dp_status_t        dp_status,
	input  logic [7:0]        revision,
	input  logic [BIN_W-1:0]  authority,
	input  logic [31:0]       sub_value,
	output logic              char_valid,
	input  logic              char_stall,
	output logic [7:0]        char_code,
	output logic              last,
	output logic              error
);

	logic [7:0]        rev_q;
	logic [BIN_W-1:0]  auth_q;
	logic [31:0]       sub_q;
	logic [BIN_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [STEP_W-1:0] step_cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  top_idx;
	logic [7:0]        digit_char;
	logic [7:0]        char_next;
	logic              char_valid_q;
	logic [7:0]        char_code_q;
	logic              last_q;
	logic              error_q;

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			rev_q  <= revision;
			auth_q <= authority;
			sub_q  <= sub_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cnt_q <= '0;
		end else if (dp_cmd.load) begin
			unique case (dp_cmd.phase)
				PH_REV:  step_cnt_q <= REV_STEPS;
				PH_AUTH: step_cnt_q <= AUTH_STEPS;
				default: step_cnt_q <= SUB_STEPS;
			endcase
		end else if (dp_cmd.step) begin
			step_cnt_q <= step_cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			bcd_q <= '0;
			unique case (dp_cmd.phase)
				PH_REV:  bin_q <= {rev_q, 40'd0};
				PH_AUTH: bin_q <= auth_q;
				default: bin_q <= {sub_q, 16'd0};
			endcase
		end else if (dp_cmd.step) begin
			bcd_q <= bcd_shift(bcd_shift(bcd_q, bin_q[BIN_W-1]), bin_q[BIN_W-2]);
			bin_q <= {bin_q[BIN_W-3:0], 2'b00};
		end
	end

	always_comb begin
		top_idx = '0;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				top_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.count) begin
			idx_q <= top_idx;
		end else if (dp_cmd.advance) begin
			idx_q <= idx_q - 4'd1;
		end
	end

	assign digit_char = CH_ZERO + {4'd0, bcd_q[{idx_q, 2'b00} +: 4]};

	always_comb begin
		unique case (dp_cmd.sel)
			SEL_S:     char_next = CH_S;
			SEL_DASH:  char_next = CH_DASH;
			SEL_DIGIT: char_next = digit_char;
			default:   char_next = CH_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else if (dp_cmd.put) begin
			char_valid_q <= 1'b1;
		end else if (!char_stall) begin
			char_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.put) begin
			char_code_q <= char_next;
			last_q      <= dp_cmd.last || (dp_cmd.sel == SEL_ERR);
			error_q     <= (dp_cmd.sel == SEL_ERR);
		end
	end

	assign dp_status.out_free  = !char_valid_q || !char_stall;
	assign dp_status.conv_done = (step_cnt_q == '0);
	assign dp_status.idx_zero  = (idx_q == '0);

	assign char_valid = char_valid_q;
	assign char_code  = char_code_q;
	assign last       = last_q;
	assign error      = error_q;

endmodule

// ===== rtl/sdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdt_ctrl
// Sequencer: checks each item against MAX_SUBS or the pending count, then
// walks the character sequence and drives the datapath commands.
// ----------------------------------------------------------------------------
module sdt_ctrl
	import sdt_pkg::*;
#(
	parameter int MAX_SUBS = MAX_SUBS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       cmd,
	input  logic [7:0] sub_count,
	output dp_cmd_t    dp_cmd,
	input  dp_status_t dp_status
);

	state_t     state_q, state_d;
	phase_t     phase_q, phase_d;
	logic [7:0] pending_q, pending_d;
	logic       final_q, final_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_REV;
			pending_q <= '0;
			final_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			pending_q <= pending_d;
			final_q   <= final_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		pending_d  = pending_q;
		final_d    = final_q;
		item_stall = (state_q != ST_IDLE);
		dp_cmd     = '0;
		dp_cmd.sel   = SEL_DIGIT;
		dp_cmd.phase = phase_q;

		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					dp_cmd.capture = 1'b1;
					if (cmd == ITEM_HDR) begin
						if (sub_count > 8'(MAX_SUBS)) begin
							pending_d = '0;
							state_d   = ST_ERR;
						end else begin
							pending_d = sub_count;
							final_d   = (sub_count == 8'd0);
							phase_d   = PH_REV;
							state_d   = ST_LEAD_S;
						end
					end else if (pending_q == 8'd0) begin
						state_d = ST_ERR;
					end else begin
						pending_d = pending_q - 8'd1;
						final_d   = (pending_q == 8'd1);
						phase_d   = PH_SUB;
						state_d   = ST_DASH;
					end
				end
			end
			ST_ERR: begin
				dp_cmd.sel = SEL_ERR;
				if (dp_status.out_free) begin
					dp_cmd.put = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_LEAD_S: begin
				dp_cmd.sel = SEL_S;
				if (dp_status.out_free) begin
					dp_cmd.put = 1'b1;
					state_d    = ST_DASH;
				end
			end
			ST_DASH: begin
				dp_cmd.sel = SEL_DASH;
				if (dp_status.out_free) begin
					dp_cmd.put = 1'b1;
					state_d    = ST_LOAD;
				end
			end
			ST_LOAD: begin
				dp_cmd.load = 1'b1;
				state_d     = ST_CONV;
			end
			ST_CONV: begin
				if (dp_status.conv_done) begin
					state_d = ST_COUNT;
				end else begin
					dp_cmd.step = 1'b1;
				end
			end
			ST_COUNT: begin
				dp_cmd.count = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				dp_cmd.sel  = SEL_DIGIT;
				dp_cmd.last = final_q && (phase_q != PH_REV) && dp_status.idx_zero;
				if (dp_status.out_free) begin
					dp_cmd.put     = 1'b1;
					dp_cmd.advance = 1'b1;
					if (dp_status.idx_zero) begin
						if (phase_q == PH_REV) begin
							phase_d = PH_AUTH;
							state_d = ST_DASH;
						end else begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/sid_to_decimal_text_core.sv =====
// ----------------------------------------------------------------------------
// sid_to_decimal_text_core
// Formats a security identifier as "S-R-A-s1-s2-..." text, one ASCII
// character per output beat.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   item    | item_valid/item_stall  | cmd revision authority sub_count
//           |                        | sub_value
//   char    | char_valid/char_stall  | char_code last error
//
// A header item converts the revision and then the 48-bit authority, the
// latter with a 24-step BCD shift. A sub-authority item uses a 16-step
// conversion. An error item emits only the error character.
// Reset is asynchronous and empties the output register and pending count.
// A stalled output holds the sequencer; item_stall stays high until the
// last character of the current item has been loaded.
// ----------------------------------------------------------------------------
module sid_to_decimal_text_core
	import sdt_pkg::*;
#(
	parameter int MAX_SUBS = MAX_SUBS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        cmd,
	input  logic [7:0]  revision,
	input  logic [47:0] authority,
	input  logic [7:0]  sub_count,
	input  logic [31:0] sub_value,
	output logic        char_valid,
	input  logic        char_stall,
	output logic [7:0]  char_code,
	output logic        last,
	output logic        error
);

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	sdt_ctrl #(
		.MAX_SUBS (MAX_SUBS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.cmd        (cmd),
		.sub_count  (sub_count),
		.dp_cmd     (dp_cmd),
		.dp_status  (dp_status)
	);

	sdt_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.dp_cmd     (dp_cmd),
		.dp_status  (dp_status),
		.revision   (revision),
		.authority  (authority),
		.sub_value  (sub_value),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.last       (last),
		.error      (error)
	);

endmodule

// ===== rtl/sdt_checker.sv =====
// ----------------------------------------------------------------------------
// sdt_checker
// Port-level checks on the formatter's output beats.
// ----------------------------------------------------------------------------
module sdt_checker
	import sdt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        char_valid,
	input logic        char_stall,
	input logic [7:0]  char_code,
	input logic        last,
	input logic        error
);

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && error) |-> (last && char_code == CH_NONE))
		else $error("error beat without last or with nonzero character");

	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && last && !error) |->
			(char_code >= CH_ZERO && char_code <= CH_NINE))
		else $error("final character is not a digit");

	a_dash_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && (char_code == CH_DASH || char_code == CH_S)) |-> (!last && !error))
		else $error("separator or lead character marked last");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && char_stall) |=> (char_valid && $stable(char_code) && $stable(last)))
		else $error("stalled output beat changed");

endmodule

bind sid_to_decimal_text_core sdt_checker u_sdt_checker (.*);
